/* hdl/vbd_pkg.sv */
// shared types and constants of the volume box downsampler
`default_nettype none
package vbd_pkg;

  localparam int DEF_MAX_SIZE_Y  = 64;
  localparam int DEF_MAX_SIZE_Z  = 64;
  localparam int DEF_MAX_FACTOR  = 16;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int LIMIT_SIZE_X = 4096;
  localparam int PX_BITS      = 12;
  localparam int ACC_BITS     = 32;
  localparam int AVG_BITS     = 16;
  localparam int CFG_BITS     = 13;
  localparam int CFG_IDX_BITS = 3;
  localparam int DIV_CNT_BITS = 5;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FACTOR_X = 3'd0,
    REG_FACTOR_Y = 3'd1,
    REG_FACTOR_Z = 3'd2,
    REG_SIZE_X   = 3'd3,
    REG_SIZE_Y   = 3'd4,
    REG_SIZE_Z   = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ACC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  typedef struct packed {
    logic capture;
    logic accumulate;
    logic div_step;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic div_last;
  } status_t;

endpackage
`default_nettype wire

/* hdl/vbd_ctrl.sv */
// controller state machine of the volume box downsampler
`default_nettype none
module vbd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire logic           out_stall,
  input  wire vbd_pkg::status_t status,
  output vbd_pkg::cmd_t       cmd
);
  import vbd_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_ACC;
      ST_ACC:  state_nxt = status.last ? ST_DIV : ST_IDLE;
      ST_DIV:  if (status.div_last) state_nxt = ST_OUT;
      ST_OUT:  if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_OUT);
  assign cmd.capture    = (state_r == ST_IDLE) && in_valid;
  assign cmd.accumulate = (state_r == ST_ACC);
  assign cmd.div_step   = (state_r == ST_DIV);

  a_capture_acc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> cmd.accumulate) else $error("capture not followed by accumulate");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid) else $error("result dropped while stalled");
  a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accumulate && !status.last |=> !in_stall) else $error("idle not reached");
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken with result pending");

endmodule
`default_nettype wire

/* hdl/vbd_datapath.sv */
// counters, partial sum store and serial divider of the volume box downsampler
`default_nettype none
module vbd_datapath #(
  parameter int MAX_SIZE_Y  = vbd_pkg::DEF_MAX_SIZE_Y,
  parameter int MAX_SIZE_Z  = vbd_pkg::DEF_MAX_SIZE_Z,
  parameter int MAX_FACTOR  = vbd_pkg::DEF_MAX_FACTOR,
  parameter int SAMPLE_BITS = vbd_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [vbd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [vbd_pkg::CFG_BITS-1:0]      cfg_data,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample,
  input  wire vbd_pkg::cmd_t                     cmd,
  output vbd_pkg::status_t                       status,
  output logic signed [vbd_pkg::AVG_BITS-1:0]    out_average,
  output logic                                   out_volume_done
);
  import vbd_pkg::*;

  localparam int PYW   = (MAX_SIZE_Y > 1) ? $clog2(MAX_SIZE_Y) : 1;
  localparam int PZW   = (MAX_SIZE_Z > 1) ? $clog2(MAX_SIZE_Z) : 1;
  localparam int SW    = $clog2(MAX_FACTOR);
  localparam int DEPTH = MAX_SIZE_Y * MAX_SIZE_Z;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_FACTOR * MAX_FACTOR * MAX_FACTOR + 1);
  localparam logic [AVG_BITS-1:0] AVG_MASK = (SAMPLE_BITS >= AVG_BITS) ?
    {AVG_BITS{1'b1}} : AVG_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

  logic [4:0] fx_r, fy_r, fz_r;
  logic [12:0] nx_r;
  logic [6:0] ny_r, nz_r;

  logic [PX_BITS-1:0] pos_x_r, pos_x_nxt;
  logic [PYW-1:0]     pos_y_r, pos_y_nxt;
  logic [PZW-1:0]     pos_z_r, pos_z_nxt;
  logic [SW-1:0]      sub_x_r, sub_x_nxt, sub_y_r, sub_y_nxt, sub_z_r, sub_z_nxt;

  int fx, fy, fz, nx, ny, nz;
  logic end_x, end_y, end_z, lst_x, lst_y, lst_z;
  logic [AW-1:0] idx;
  logic [CW-1:0] count;

  logic [ACC_BITS-1:0] sample_r, rd_q_r, acc, acc_mag;
  logic [AW-1:0]       idx_r;
  logic [CW-1:0]       count_r;
  logic                first_r, last_r, done_r, neg_r;
  logic [ACC_BITS-1:0] quo_r;
  logic [CW-1:0]       rem_r;
  logic [DIV_CNT_BITS-1:0] div_cnt_r;
  logic [CW:0]         rem_sh;
  logic                q_bit;
  logic [ACC_BITS-1:0] res;

  logic [ACC_BITS-1:0] mem [DEPTH];

  function automatic int clampv(input int v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  always_comb begin
    fx = clampv(int'(fx_r), MAX_FACTOR);
    fy = clampv(int'(fy_r), MAX_FACTOR);
    fz = clampv(int'(fz_r), MAX_FACTOR);
    nx = clampv(int'(nx_r), LIMIT_SIZE_X);
    ny = clampv(int'(ny_r), MAX_SIZE_Y);
    nz = clampv(int'(nz_r), MAX_SIZE_Z);
    end_x = (int'(pos_x_r) + 1 >= nx);
    end_y = (int'(pos_y_r) + 1 >= ny);
    end_z = (int'(pos_z_r) + 1 >= nz);
    lst_x = (int'(sub_x_r) + 1 >= fx) || end_x;
    lst_y = (int'(sub_y_r) + 1 >= fy) || end_y;
    lst_z = (int'(sub_z_r) + 1 >= fz) || end_z;
    idx   = AW'((int'(pos_y_r) - int'(sub_y_r)) * MAX_SIZE_Z
                + (int'(pos_z_r) - int'(sub_z_r)));
    count = CW'((int'(sub_x_r) + 1) * (int'(sub_y_r) + 1) * (int'(sub_z_r) + 1));

    // z fastest, carries ripple to y then x
    pos_x_nxt = pos_x_r; pos_y_nxt = pos_y_r; pos_z_nxt = pos_z_r;
    sub_x_nxt = sub_x_r; sub_y_nxt = sub_y_r; sub_z_nxt = sub_z_r;
    if (end_z) begin
      pos_z_nxt = '0;
      sub_z_nxt = '0;
      if (end_y) begin
        pos_y_nxt = '0;
        sub_y_nxt = '0;
        if (end_x) begin
          pos_x_nxt = '0;
          sub_x_nxt = '0;
        end else begin
          pos_x_nxt = pos_x_r + 1'b1;
          sub_x_nxt = (int'(sub_x_r) + 1 >= fx) ? '0 : sub_x_r + 1'b1;
        end
      end else begin
        pos_y_nxt = pos_y_r + 1'b1;
        sub_y_nxt = (int'(sub_y_r) + 1 >= fy) ? '0 : sub_y_r + 1'b1;
      end
    end else begin
      pos_z_nxt = pos_z_r + 1'b1;
      sub_z_nxt = (int'(sub_z_r) + 1 >= fz) ? '0 : sub_z_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fx_r <= 5'd1; fy_r <= 5'd1; fz_r <= 5'd1;
      nx_r <= 13'd64; ny_r <= 7'd64; nz_r <= 7'd64;
      pos_x_r <= '0; pos_y_r <= '0; pos_z_r <= '0;
      sub_x_r <= '0; sub_y_r <= '0; sub_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FACTOR_X: fx_r <= cfg_data[4:0];
        REG_FACTOR_Y: fy_r <= cfg_data[4:0];
        REG_FACTOR_Z: fz_r <= cfg_data[4:0];
        REG_SIZE_X:   nx_r <= cfg_data;
        REG_SIZE_Y:   ny_r <= cfg_data[6:0];
        REG_SIZE_Z:   nz_r <= cfg_data[6:0];
        default: ;
      endcase
      // any known register write restarts the volume
      if (cfg_index <= REG_SIZE_Z) begin
        pos_x_r <= '0; pos_y_r <= '0; pos_z_r <= '0;
        sub_x_r <= '0; sub_y_r <= '0; sub_z_r <= '0;
      end
    end else if (cmd.capture) begin
      pos_x_r <= pos_x_nxt; pos_y_r <= pos_y_nxt; pos_z_r <= pos_z_nxt;
      sub_x_r <= sub_x_nxt; sub_y_r <= sub_y_nxt; sub_z_r <= sub_z_nxt;
    end
  end

  // beat capture and store read
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r <= ACC_BITS'(in_sample);
      idx_r    <= idx;
      count_r  <= count;
      first_r  <= (sub_x_r == '0) && (sub_y_r == '0) && (sub_z_r == '0);
      last_r   <= lst_x && lst_y && lst_z;
      done_r   <= end_x && end_y && end_z;
      rd_q_r   <= mem[idx];
    end
    if (cmd.accumulate) mem[idx_r] <= acc;
  end

  assign acc     = first_r ? sample_r : rd_q_r + sample_r;
  assign acc_mag = acc[ACC_BITS-1] ? (~acc + 1'b1) : acc;

  // restoring divide, one quotient bit a cycle
  assign rem_sh = {rem_r, quo_r[ACC_BITS-1]};
  assign q_bit  = (rem_sh >= {1'b0, count_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.accumulate) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accumulate) begin
      quo_r <= acc_mag;
      rem_r <= '0;
      neg_r <= acc[ACC_BITS-1];
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[ACC_BITS-2:0], q_bit};
      rem_r <= q_bit ? CW'(rem_sh - {1'b0, count_r}) : CW'(rem_sh);
    end
  end

  assign res             = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign out_average     = res[AVG_BITS-1:0] & AVG_MASK;
  assign out_volume_done = done_r;
  assign status.last     = last_r;
  assign status.div_last = (div_cnt_r == {DIV_CNT_BITS{1'b1}});

endmodule
`default_nettype wire

/* hdl/volume_box_downsample_unit.sv */
// top level of the volume box downsampler
`default_nettype none
// Averages boxes of factor_x by factor_y by factor_z samples of a volume streamed
// x outermost, z innermost; edge boxes are divided by their true sample count,
// truncated toward zero. One sample is taken at a time: a sample that closes no
// box is captured with a store read, then accumulated and written back; a sample
// that closes a box is captured, accumulated, run through the 32-step serial
// divider and then held in the output beat while out_stall is high. A write to
// a known register restarts the volume. The partial sum store is
// MAX_SIZE_Y*MAX_SIZE_Z words and needs no clearing after reset.
module volume_box_downsample_unit #(
  parameter int MAX_SIZE_Y  = vbd_pkg::DEF_MAX_SIZE_Y,
  parameter int MAX_SIZE_Z  = vbd_pkg::DEF_MAX_SIZE_Z,
  parameter int MAX_FACTOR  = vbd_pkg::DEF_MAX_FACTOR,
  parameter int SAMPLE_BITS = vbd_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [vbd_pkg::AVG_BITS-1:0]    out_average,
  output logic                                   out_volume_done,
  input  wire logic                              cfg_we,
  input  wire logic [vbd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  wire logic [vbd_pkg::CFG_BITS-1:0]      cfg_data
);
  import vbd_pkg::*;

  cmd_t    cmd;
  status_t status;

  vbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  vbd_datapath #(
    .MAX_SIZE_Y  (MAX_SIZE_Y),
    .MAX_SIZE_Z  (MAX_SIZE_Z),
    .MAX_FACTOR  (MAX_FACTOR),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_sample       (in_sample),
    .cmd             (cmd),
    .status          (status),
    .out_average     (out_average),
    .out_volume_done (out_volume_done)
  );

endmodule
`default_nettype wire
